>>> rtl/core/sbhs_pkg.sv
// Package: beat types, protocol codes and constants for the bootloader host sequencer.
`default_nettype none
package sbhs_pkg;

    localparam int MaxBlockDefault = 256;
    localparam int MaxRes          = 5;
    localparam int CfgIdxW         = 2;
    localparam int CfgDataW        = 4;

    typedef struct packed {
        logic [1:0]  action;
        logic [2:0]  op;
        logic [31:0] address;
        logic [8:0]  length;
        logic [7:0]  byte_in;
    } t_in_item;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] byte_out;
        logic [2:0] status;
        logic       last;
    } t_out_item;

    // input actions
    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_RX    = 2'd1;
    localparam logic [1:0] ACT_TMO   = 2'd2;
    localparam logic [1:0] ACT_PAY   = 2'd3;

    // operations; OP_EXT_ERASE is internal only
    localparam logic [2:0] OP_SYNC      = 3'd0;
    localparam logic [2:0] OP_READ      = 3'd1;
    localparam logic [2:0] OP_WRITE     = 3'd2;
    localparam logic [2:0] OP_GO        = 3'd3;
    localparam logic [2:0] OP_ERASE     = 3'd4;
    localparam logic [2:0] OP_EXT_ERASE = 3'd5;

    // result kinds
    localparam logic [1:0] KIND_TX     = 2'd0;
    localparam logic [1:0] KIND_DATA   = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // completion status
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NACK    = 3'd1;
    localparam logic [2:0] ST_TIMEOUT = 3'd2;
    localparam logic [2:0] ST_BAD     = 3'd3;
    localparam logic [2:0] ST_NOSYNC  = 3'd4;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_EXT_ERASE = CfgIdxW'(0);
    localparam logic [CfgIdxW-1:0] CFG_SYNC_TRY  = CfgIdxW'(1);

    // protocol bytes
    localparam logic [7:0] B_ACK       = 8'h79;
    localparam logic [7:0] B_NACK      = 8'h1F;
    localparam logic [7:0] B_SYNC      = 8'h7F;
    localparam logic [7:0] B_READ      = 8'h11;
    localparam logic [7:0] B_WRITE     = 8'h31;
    localparam logic [7:0] B_GO        = 8'h21;
    localparam logic [7:0] B_ERASE     = 8'h43;
    localparam logic [7:0] B_EXT_ERASE = 8'h44;
    localparam logic [7:0] B_FF        = 8'hFF;
    localparam logic [7:0] B_00        = 8'h00;

    localparam logic [3:0] SYNC_TRY_RST = 4'd4;

    function automatic t_out_item mk_res(input logic [1:0] kind, input logic [7:0] b,
                                         input logic [2:0] st);
        t_out_item r;
        r.kind     = kind;
        r.byte_out = b;
        r.status   = st;
        r.last     = 1'b0;
        return r;
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/serial_bootloader_host_sequencer.sv
// Host sequencer for a UART bootloader command exchange (sync, read, write, go, erase).
//
// Channels: an input beat is a start request, a byte received from the target, a receive
// timeout or a write payload byte. Each input beat yields zero to five result beats:
// bytes to transmit, read data bytes and one completion status per operation; the final
// result beat of an input beat carries last. A config write port (valid/ready, always
// ready) sets extended erase and the sync attempt budget; write it only while idle.
// Results of a taken input beat pass from the input register to the result burst buffer
// and then the output register. Throughput: one input per cycle for inputs that yield at
// most one result while the receiver is ready; an input yielding more holds the burst
// buffer until its beats drain, one per cycle while the receiver is ready, and the input
// register holds the next beat meanwhile. Reset (synchronous, active low) returns the protocol
// to idle, clears protocol state and valid flags and sets standard erase and four sync attempts.
// A stalled receiver holds the output register; the burst buffer and then the input
// register fill and the input side deasserts ready. No beat is dropped.
`default_nettype none
module serial_bootloader_host_sequencer #(
    parameter int MAX_BLOCK = sbhs_pkg::MaxBlockDefault
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_in_valid,
    output logic                                  o_in_ready,
    input  wire  sbhs_pkg::t_in_item              i_in_item,
    output logic                                  o_out_valid,
    input  wire                                   i_out_ready,
    output sbhs_pkg::t_out_item                   o_out_item,
    input  wire                                   i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire  [sbhs_pkg::CfgIdxW-1:0]          i_cfg_index,
    input  wire  [sbhs_pkg::CfgDataW-1:0]         i_cfg_data
);
    import sbhs_pkg::*;

    localparam logic [3:0] PH_IDLE  = 4'd0;
    localparam logic [3:0] PH_SYNC  = 4'd1;
    localparam logic [3:0] PH_CMD   = 4'd2;
    localparam logic [3:0] PH_ADDR  = 4'd3;
    localparam logic [3:0] PH_RLEN  = 4'd4;
    localparam logic [3:0] PH_RDATA = 4'd5;
    localparam logic [3:0] PH_WDATA = 4'd6;
    localparam logic [3:0] PH_WACK  = 4'd7;
    localparam logic [3:0] PH_EACK  = 4'd8;

    localparam logic [8:0] MaxLen = 9'(MAX_BLOCK);

    // config
    logic       r_ext_erase;
    logic [3:0] r_sync_try;

    // protocol state
    logic [3:0]  r_phase,    n_phase;
    logic [2:0]  r_cur_op,   n_cur_op;
    logic [31:0] r_addr,     n_addr;
    logic [8:0]  r_len,      n_len;
    logic [8:0]  r_bcnt,     n_bcnt;
    logic [7:0]  r_cks,      n_cks;
    logic [3:0]  r_tries,    n_tries;

    // pipeline
    logic      r_in_valid;
    t_in_item  r_in;
    t_out_item r_bst [MaxRes];
    logic [2:0] r_left;
    logic      r_out_valid;
    t_out_item r_out;

    t_out_item res [MaxRes];
    logic [2:0] cnt;
    logic      out_free, pop, burst_free, proc;

    logic [7:0] a3, a2, a1, a0, lm1, b;
    logic [8:0] bcnt_inc;
    logic       len_ok;

    assign out_free   = !r_out_valid || i_out_ready;
    assign pop        = (r_left != 3'd0) && out_free;
    assign burst_free = (r_left == 3'd0) || ((r_left == 3'd1) && pop);
    assign proc       = r_in_valid && burst_free;

    assign o_in_ready  = !r_in_valid || proc;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign a3       = r_addr[31:24];
    assign a2       = r_addr[23:16];
    assign a1       = r_addr[15:8];
    assign a0       = r_addr[7:0];
    assign lm1      = 8'(r_len - 9'd1);
    assign b        = r_in.byte_in;
    assign bcnt_inc = r_bcnt + 9'd1;
    assign len_ok   = (r_in.length != 9'd0) && (r_in.length <= MaxLen);

    always_comb begin
        n_phase  = r_phase;
        n_cur_op = r_cur_op;
        n_addr   = r_addr;
        n_len    = r_len;
        n_bcnt   = r_bcnt;
        n_cks    = r_cks;
        n_tries  = r_tries;
        cnt      = 3'd0;
        for (int i = 0; i < MaxRes; i++) begin
            res[i] = '0;
        end

        case (r_in.action)
            ACT_START: begin
                if (r_phase != PH_IDLE) begin
                    res[0] = mk_res(KIND_STATUS, B_00, ST_BAD);
                    cnt    = 3'd1;
                end else begin
                    case (r_in.op)
                        OP_SYNC: begin
                            n_cur_op = OP_SYNC;
                            n_tries  = (r_sync_try != 4'd0) ? r_sync_try - 4'd1 : 4'd0;
                            n_phase  = PH_SYNC;
                            res[0]   = mk_res(KIND_TX, B_SYNC, ST_OK);
                            cnt      = 3'd1;
                        end
                        OP_READ, OP_WRITE: begin
                            if (!len_ok || ((r_in.op == OP_WRITE) &&
                                            (r_in.length[1:0] != 2'b00))) begin
                                res[0] = mk_res(KIND_STATUS, B_00, ST_BAD);
                                cnt    = 3'd1;
                            end else begin
                                n_cur_op = r_in.op;
                                n_addr   = r_in.address;
                                n_len    = r_in.length;
                                n_phase  = PH_CMD;
                                if (r_in.op == OP_READ) begin
                                    res[0] = mk_res(KIND_TX, B_READ, ST_OK);
                                    res[1] = mk_res(KIND_TX, ~B_READ, ST_OK);
                                end else begin
                                    res[0] = mk_res(KIND_TX, B_WRITE, ST_OK);
                                    res[1] = mk_res(KIND_TX, ~B_WRITE, ST_OK);
                                end
                                cnt = 3'd2;
                            end
                        end
                        OP_GO: begin
                            n_cur_op = OP_GO;
                            n_addr   = r_in.address;
                            n_phase  = PH_CMD;
                            res[0]   = mk_res(KIND_TX, B_GO, ST_OK);
                            res[1]   = mk_res(KIND_TX, ~B_GO, ST_OK);
                            cnt      = 3'd2;
                        end
                        OP_ERASE: begin
                            n_phase = PH_CMD;
                            if (r_ext_erase) begin
                                n_cur_op = OP_EXT_ERASE;
                                res[0]   = mk_res(KIND_TX, B_EXT_ERASE, ST_OK);
                                res[1]   = mk_res(KIND_TX, ~B_EXT_ERASE, ST_OK);
                            end else begin
                                n_cur_op = OP_ERASE;
                                res[0]   = mk_res(KIND_TX, B_ERASE, ST_OK);
                                res[1]   = mk_res(KIND_TX, ~B_ERASE, ST_OK);
                            end
                            cnt = 3'd2;
                        end
                        default: begin
                            res[0] = mk_res(KIND_STATUS, B_00, ST_BAD);
                            cnt    = 3'd1;
                        end
                    endcase
                end
            end
            ACT_RX, ACT_TMO: begin
                if (r_phase == PH_SYNC) begin
                    if ((r_in.action == ACT_RX) && ((b == B_ACK) || (b == B_NACK))) begin
                        n_phase = PH_IDLE;
                        res[0]  = mk_res(KIND_STATUS, B_00, ST_OK);
                    end else if (r_tries != 4'd0) begin
                        n_tries = r_tries - 4'd1;
                        res[0]  = mk_res(KIND_TX, B_SYNC, ST_OK);
                    end else begin
                        n_phase = PH_IDLE;
                        res[0]  = mk_res(KIND_STATUS, B_00, ST_NOSYNC);
                    end
                    cnt = 3'd1;
                end else if ((r_phase == PH_RDATA) && (r_in.action == ACT_RX)) begin
                    res[0] = mk_res(KIND_DATA, b, ST_OK);
                    cnt    = 3'd1;
                    n_bcnt = bcnt_inc;
                    if (bcnt_inc >= r_len) begin
                        n_phase = PH_IDLE;
                        res[1]  = mk_res(KIND_STATUS, B_00, ST_OK);
                        cnt     = 3'd2;
                    end
                end else if ((r_phase != PH_IDLE) && (r_phase != PH_WDATA)) begin
                    if (r_in.action == ACT_TMO) begin
                        n_phase = PH_IDLE;
                        res[0]  = mk_res(KIND_STATUS, B_00, ST_TIMEOUT);
                        cnt     = 3'd1;
                    end else if (b != B_ACK) begin
                        n_phase = PH_IDLE;
                        res[0]  = mk_res(KIND_STATUS, B_00, ST_NACK);
                        cnt     = 3'd1;
                    end else begin
                        case (r_phase)
                            PH_CMD: begin
                                if (r_cur_op == OP_ERASE) begin
                                    res[0]  = mk_res(KIND_TX, B_FF, ST_OK);
                                    res[1]  = mk_res(KIND_TX, B_00, ST_OK);
                                    cnt     = 3'd2;
                                    n_phase = PH_EACK;
                                end else if (r_cur_op == OP_EXT_ERASE) begin
                                    res[0]  = mk_res(KIND_TX, B_FF, ST_OK);
                                    res[1]  = mk_res(KIND_TX, B_FF, ST_OK);
                                    res[2]  = mk_res(KIND_TX, B_00, ST_OK);
                                    cnt     = 3'd3;
                                    n_phase = PH_EACK;
                                end else begin
                                    res[0]  = mk_res(KIND_TX, a3, ST_OK);
                                    res[1]  = mk_res(KIND_TX, a2, ST_OK);
                                    res[2]  = mk_res(KIND_TX, a1, ST_OK);
                                    res[3]  = mk_res(KIND_TX, a0, ST_OK);
                                    res[4]  = mk_res(KIND_TX, a3 ^ a2 ^ a1 ^ a0, ST_OK);
                                    cnt     = 3'd5;
                                    n_phase = PH_ADDR;
                                end
                            end
                            PH_ADDR: begin
                                if (r_cur_op == OP_READ) begin
                                    res[0]  = mk_res(KIND_TX, lm1, ST_OK);
                                    res[1]  = mk_res(KIND_TX, ~lm1, ST_OK);
                                    cnt     = 3'd2;
                                    n_phase = PH_RLEN;
                                end else if (r_cur_op == OP_WRITE) begin
                                    n_cks   = lm1;
                                    n_bcnt  = 9'd0;
                                    n_phase = PH_WDATA;
                                    res[0]  = mk_res(KIND_TX, lm1, ST_OK);
                                    cnt     = 3'd1;
                                end else begin
                                    n_phase = PH_IDLE;
                                    res[0]  = mk_res(KIND_STATUS, B_00, ST_OK);
                                    cnt     = 3'd1;
                                end
                            end
                            PH_RLEN: begin
                                n_bcnt  = 9'd0;
                                n_phase = PH_RDATA;
                            end
                            default: begin
                                n_phase = PH_IDLE;
                                res[0]  = mk_res(KIND_STATUS, B_00, ST_OK);
                                cnt     = 3'd1;
                            end
                        endcase
                    end
                end
            end
            ACT_PAY: begin
                if (r_phase == PH_WDATA) begin
                    res[0] = mk_res(KIND_TX, b, ST_OK);
                    cnt    = 3'd1;
                    n_cks  = r_cks ^ b;
                    n_bcnt = bcnt_inc;
                    if (bcnt_inc >= r_len) begin
                        res[1]  = mk_res(KIND_TX, r_cks ^ b, ST_OK);
                        cnt     = 3'd2;
                        n_phase = PH_WACK;
                    end
                end
            end
            default: begin
                cnt = 3'd0;
            end
        endcase

        for (int i = 0; i < MaxRes; i++) begin
            res[i].last = (3'(i) == (cnt - 3'd1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ext_erase <= 1'b0;
            r_sync_try  <= SYNC_TRY_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_EXT_ERASE) begin
                r_ext_erase <= i_cfg_data[0];
            end else if (i_cfg_index == CFG_SYNC_TRY) begin
                r_sync_try <= i_cfg_data[3:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_cur_op <= OP_SYNC;
            r_addr   <= '0;
            r_len    <= '0;
            r_bcnt   <= '0;
            r_cks    <= '0;
            r_tries  <= '0;
        end else if (proc) begin
            r_phase  <= n_phase;
            r_cur_op <= n_cur_op;
            r_addr   <= n_addr;
            r_len    <= n_len;
            r_bcnt   <= n_bcnt;
            r_cks    <= n_cks;
            r_tries  <= n_tries;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    // result burst: loaded whole, drained from the head
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 3'd0;
        end else if (proc) begin
            r_left <= cnt;
        end else if (pop) begin
            r_left <= r_left - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc) begin
            for (int i = 0; i < MaxRes; i++) begin
                r_bst[i] <= res[i];
            end
        end else if (pop) begin
            for (int i = 0; i < MaxRes - 1; i++) begin
                r_bst[i] <= r_bst[i+1];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out <= r_bst[0];
        end
    end

    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= 3'(MaxRes))
        else $error("burst count exceeds result limit");

    a_final_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && (r_left == 3'd1)) |-> r_bst[0].last)
        else $error("final beat of a burst lacks last");

    a_mid_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && (r_left > 3'd1)) |-> !r_bst[0].last)
        else $error("last flagged before end of burst");

    a_wdata_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_WDATA) |-> (r_cur_op == OP_WRITE))
        else $error("payload phase outside a write");

    a_rdata_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_phase == PH_RDATA) || (r_phase == PH_RLEN)) |-> (r_cur_op == OP_READ))
        else $error("read data phase outside a read");

endmodule
`default_nettype wire
